// File: sv/rae_pkg.sv
// Shared types and constants for the Roe-average eigensystem unit.
// No dependencies; imported by rae_alu, rae_back and the top level.
package rae_pkg;

    localparam int GAMMA_WIDTH = 18;
    localparam int OUT_WIDTH   = 32;
    localparam int NUM_ENTRIES = 21;
    localparam int IDX_WIDTH   = 5;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_DENSITY = 2'd1;
    localparam logic [1:0] ERR_SOUND   = 2'd2;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef enum logic [1:0] {
        EM_PASS,
        EM_ADD,
        EM_SUB,
        EM_NADD
    } t_emit_mode;

    typedef enum logic [5:0] {
        S_IDLE, S_VL, S_VR, S_GEL, S_TL, S_K, S_XL1, S_XL2, S_HL,
        S_GER, S_TR, S_XR1, S_XR2, S_HR, S_SL, S_SR, S_SSUM,
        S_H1, S_H2, S_H3, S_HB, S_U1, S_U2, S_U3, S_UB,
        S_C1, S_C2, S_CP, S_CC, S_C, S_UC, S_E10A, S_E10,
        S_IC, S_B1A, S_B1B, S_B1, S_V, S_W1, S_W, S_Q, S_QE,
        S_TW, S_TV, S_TB, S_EMIT, S_ERR
    } t_state;

    typedef struct packed {
        logic [IDX_WIDTH-1:0]        entry_index;
        logic signed [OUT_WIDTH-1:0] entry_value;
        logic [1:0]                  error_code;
        logic                        last_entry;
    } t_result;

endpackage

// File: sv/rae_fifo.sv
// Small register queue used between the front and back, and on the result side.
// No package dependencies.
module rae_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: sv/rae_alu.sv
// Shared iterative unit: fixed-point multiply (16-bit digit per cycle),
// restoring divide and square root (one step per cycle). Uses rae_pkg.
module rae_alu #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  rae_pkg::t_alu_op      i_op,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic                  o_done,
    output logic signed [W-1:0]   o_res
);
    import rae_pkg::*;

    localparam int NW  = W + F;
    localparam int XW  = NW + (NW % 2);
    localparam int NR  = XW / 2;
    localparam int DG  = 16;
    localparam int ND  = (W + DG - 1) / DG;
    localparam int MBW = ND * DG;
    localparam int PW  = W + MBW;
    localparam int CW  = $clog2(NW + 1);
    localparam logic [W:0] LIM_POS = {2'b00, {(W-1){1'b1}}};
    localparam logic [W:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};

    logic          r_busy;
    t_alu_op       r_op;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic          r_zero;
    logic          r_dz;
    logic [W-1:0]  r_ma;
    logic [MBW-1:0] r_mb;
    logic [PW-1:0] r_acc;
    logic [NW-1:0] r_num;
    logic [W:0]    r_rem;
    logic [NW-1:0] r_q;
    logic [W-1:0]  r_dv;
    logic [XW-1:0] r_x;
    logic [NR+1:0] r_srem;
    logic [NR-1:0] r_root;

    logic [W-1:0]    mag_a;
    logic [W-1:0]    mag_b;
    logic [W+DG-1:0] pp;
    logic [W:0]      rem2;
    logic            div_take;
    logic [NR+1:0]   srem2;
    logic [NR+1:0]   trial;
    logic            sq_take;
    logic [PW-1:0]   rnd;
    logic [PW-1:0]   shf;
    logic [W:0]      lim;
    logic [W:0]      m;
    logic [W:0]      sres;

    assign mag_a = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign mag_b = i_b[W-1] ? (~i_b + 1'b1) : i_b;

    always_comb begin
        pp       = r_ma * r_mb[MBW-1 -: DG];
        rem2     = {r_rem[W-1:0], r_num[NW-1]};
        div_take = (rem2 >= {1'b0, r_dv});
        srem2    = {r_srem[NR-1:0], r_x[XW-1 -: 2]};
        trial    = {r_root, 2'b01};
        sq_take  = (srem2 >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            unique case (i_op)
                ALU_MUL:  r_cnt <= CW'(ND);
                ALU_DIV:  r_cnt <= CW'(NW);
                ALU_SQRT: r_cnt <= CW'(NR);
                default:  r_cnt <= CW'(NR);
            endcase
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= i_op;
            r_neg  <= (i_op == ALU_SQRT) ? 1'b0 : (i_a[W-1] ^ i_b[W-1]);
            r_zero <= (i_op == ALU_SQRT) ? (i_a[W-1] || (i_a == '0)) : (i_a == '0);
            r_dz   <= (i_b == '0);
            r_ma   <= mag_a;
            r_mb   <= MBW'(mag_b);
            r_acc  <= '0;
            r_num  <= {mag_a, {F{1'b0}}};
            r_rem  <= '0;
            r_q    <= '0;
            r_dv   <= mag_b;
            r_x    <= XW'({i_a, {F{1'b0}}});
            r_srem <= '0;
            r_root <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            unique case (r_op)
                ALU_MUL: begin
                    r_acc <= (r_acc << DG) + PW'(pp);
                    r_mb  <= r_mb << DG;
                end
                ALU_DIV: begin
                    r_rem <= div_take ? (rem2 - {1'b0, r_dv}) : rem2;
                    r_q   <= {r_q[NW-2:0], div_take};
                    r_num <= r_num << 1;
                end
                ALU_SQRT: begin
                    r_srem <= sq_take ? (srem2 - trial) : srem2;
                    r_root <= {r_root[NR-2:0], sq_take};
                    r_x    <= r_x << 2;
                end
                default: begin
                    r_x <= r_x;
                end
            endcase
        end
    end

    // magnitude of the final result, saturated to the signed working word
    always_comb begin
        lim = r_neg ? LIM_NEG : LIM_POS;
        rnd = r_acc + (PW'(1) << (F - 1));
        shf = rnd >> F;
        unique case (r_op)
            ALU_MUL: m = (shf > PW'(lim)) ? lim : shf[W:0];
            ALU_DIV: begin
                if (r_dz) begin
                    m = r_zero ? '0 : lim;
                end else begin
                    m = (r_q > NW'(lim)) ? lim : r_q[W:0];
                end
            end
            ALU_SQRT: m = r_zero ? '0 : (W+1)'(r_root);
            default:  m = '0;
        endcase
        sres = r_neg ? (~m + 1'b1) : m;
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_res  = sres[W-1:0];

endmodule

// File: sv/rae_front.sv
// Front part: takes input beats, saturates them to the working word, flags
// non-positive density, and queues them for the back part. Uses rae_fifo.
module rae_front #(
    parameter int W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic signed [31:0]    i_left_density,
    input  logic signed [31:0]    i_left_momentum,
    input  logic signed [31:0]    i_left_energy,
    input  logic signed [31:0]    i_right_density,
    input  logic signed [31:0]    i_right_momentum,
    input  logic signed [31:0]    i_right_energy,
    output logic                  o_item_valid,
    output logic [6*W:0]          o_item,
    input  logic                  i_item_pop
);
    localparam logic signed [64:0] WMAX_X = (65'sd1 <<< (W - 1)) - 65'sd1;
    localparam logic signed [64:0] WMIN_X = -WMAX_X - 65'sd1;

    function automatic logic signed [W-1:0] clamp_in(input logic signed [31:0] v);
        logic signed [64:0] e;
        e = 65'(v);
        if (e > WMAX_X) begin
            clamp_in = WMAX_X[W-1:0];
        end else if (e < WMIN_X) begin
            clamp_in = WMIN_X[W-1:0];
        end else begin
            clamp_in = e[W-1:0];
        end
    endfunction

    logic signed [W-1:0] dl;
    logic signed [W-1:0] dr;
    logic                dens_err;
    logic                q_empty;
    logic [6*W:0]        item;

    assign dl       = clamp_in(i_left_density);
    assign dr       = clamp_in(i_right_density);
    assign dens_err = (dl <= 0) || (dr <= 0);
    assign item     = {dens_err, dl, clamp_in(i_left_momentum), clamp_in(i_left_energy),
                       dr, clamp_in(i_right_momentum), clamp_in(i_right_energy)};

    rae_fifo #(
        .WIDTH(6*W + 1),
        .DEPTH(2)
    ) u_item_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (item),
        .o_full  (full),
        .i_pop   (i_item_pop),
        .o_data  (o_item),
        .o_empty (q_empty)
    );

    assign o_item_valid = !q_empty;

endmodule

// File: sv/rae_back.sv
// Back part: sequencer that runs the Roe average and eigensystem through the
// shared unit and a local saturating adder, then emits the 21 entries or one error beat. Uses rae_pkg and rae_alu.
module rae_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [rae_pkg::GAMMA_WIDTH-1:0]   i_gamma,
    input  logic                              i_item_valid,
    input  logic [6*W:0]                      i_item,
    output logic                              o_item_pop,
    output logic                              o_res_push,
    output rae_pkg::t_result                  o_res,
    input  logic                              i_res_full
);
    import rae_pkg::*;

    localparam logic signed [64:0] WMAX_X = (65'sd1 <<< (W - 1)) - 65'sd1;
    localparam logic signed [64:0] ONE_X  = 65'sd1 <<< F;
    localparam logic signed [64:0] HALF_X = 65'sd1 <<< (F - 1);
    localparam logic signed [64:0] TWO_X  = 65'sd2 <<< F;
    localparam logic signed [W-1:0] C_ONE  = (ONE_X > WMAX_X) ? WMAX_X[W-1:0] : ONE_X[W-1:0];
    localparam logic signed [W-1:0] C_HALF =
        (HALF_X > WMAX_X) ? WMAX_X[W-1:0] : HALF_X[W-1:0];
    localparam logic signed [W-1:0] C_TWO  = (TWO_X > WMAX_X) ? WMAX_X[W-1:0] : TWO_X[W-1:0];
    localparam logic signed [W-1:0] C_NHALF = -C_HALF;
    localparam logic signed [W-1:0] C_NTWO  = -C_TWO;
    localparam logic signed [W-1:0] C_MIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] C_MAX   = {1'b0, {(W-1){1'b1}}};

    function automatic logic signed [W-1:0] fadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            fadd = s[W] ? C_MIN : C_MAX;
        end else begin
            fadd = s[W-1:0];
        end
    endfunction

    function automatic logic signed [W-1:0] fneg(input logic signed [W-1:0] a);
        fneg = (a == C_MIN) ? C_MAX : -a;
    endfunction

    function automatic logic signed [31:0] out32(input logic signed [W-1:0] v);
        logic signed [64:0] e;
        e = 65'(v);
        if (e > 65'sd2147483647) begin
            out32 = 32'sh7fffffff;
        end else if (e < -65'sd2147483648) begin
            out32 = 32'sh80000000;
        end else begin
            out32 = e[31:0];
        end
    endfunction

    t_state r_state;
    t_state n_state;
    logic   r_wait;
    logic [IDX_WIDTH-1:0] r_k;
    logic [1:0] r_err;

    logic signed [W-1:0] r_dl, r_ml, r_el, r_dr, r_mr, r_er, r_dif;
    logic signed [W-1:0] r_vl, r_vr, r_t, r_k2, r_x, r_y, r_hl, r_hr;
    logic signed [W-1:0] r_sl, r_sr, r_ssum, r_hb, r_ub, r_cp, r_c2, r_c, r_uc;
    logic signed [W-1:0] r_e10, r_ic, r_b1, r_v, r_w, r_q, r_qe, r_tw, r_tv, r_tb;

    logic signed [W-1:0] gam;
    logic                is_alu;
    logic                alu_start;
    t_alu_op             alu_op;
    logic signed [W-1:0] alu_a, alu_b, alu_res;
    logic                alu_done;
    logic signed [W-1:0] add_a, add_b, add_res, res_val;
    logic                step_done;
    logic                not_pos;
    t_emit_mode          em_mode;
    logic signed [W-1:0] em_a, em_b, em_val;
    logic                em_last;

    assign gam = W'(i_gamma);

    rae_alu #(
        .W(W),
        .F(F)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // operand selection per step
    always_comb begin
        is_alu = 1'b1;
        alu_op = ALU_MUL;
        alu_a  = '0;
        alu_b  = '0;
        add_a  = '0;
        add_b  = '0;
        unique case (r_state)
            S_VL:   begin alu_op = ALU_DIV;  alu_a = r_ml;    alu_b = r_dl; end
            S_VR:   begin alu_op = ALU_DIV;  alu_a = r_mr;    alu_b = r_dr; end
            S_GEL:  begin alu_a = gam;       alu_b = r_el; end
            S_TL:   begin alu_op = ALU_DIV;  alu_a = r_t;     alu_b = r_dl; end
            S_K:    begin alu_a = C_NHALF;   alu_b = r_dif; end
            S_XL1:  begin alu_a = r_k2;      alu_b = r_vl; end
            S_XL2:  begin alu_a = r_x;       alu_b = r_vl; end
            S_HL:   begin is_alu = 1'b0;     add_a = r_x;     add_b = r_t; end
            S_GER:  begin alu_a = gam;       alu_b = r_er; end
            S_TR:   begin alu_op = ALU_DIV;  alu_a = r_t;     alu_b = r_dr; end
            S_XR1:  begin alu_a = r_k2;      alu_b = r_vr; end
            S_XR2:  begin alu_a = r_x;       alu_b = r_vr; end
            S_HR:   begin is_alu = 1'b0;     add_a = r_x;     add_b = r_t; end
            S_SL:   begin alu_op = ALU_SQRT; alu_a = r_dl; end
            S_SR:   begin alu_op = ALU_SQRT; alu_a = r_dr; end
            S_SSUM: begin is_alu = 1'b0;     add_a = r_sl;    add_b = r_sr; end
            S_H1:   begin alu_a = r_sr;      alu_b = r_hr; end
            S_H2:   begin alu_a = r_sl;      alu_b = r_hl; end
            S_H3:   begin is_alu = 1'b0;     add_a = r_x;     add_b = r_y; end
            S_HB:   begin alu_op = ALU_DIV;  alu_a = r_x;     alu_b = r_ssum; end
            S_U1:   begin alu_a = r_sr;      alu_b = r_vr; end
            S_U2:   begin alu_a = r_sl;      alu_b = r_vl; end
            S_U3:   begin is_alu = 1'b0;     add_a = r_x;     add_b = r_y; end
            S_UB:   begin alu_op = ALU_DIV;  alu_a = r_x;     alu_b = r_ssum; end
            S_C1:   begin alu_a = C_NHALF;   alu_b = r_ub; end
            S_C2:   begin alu_a = r_x;       alu_b = r_ub; end
            S_CP:   begin is_alu = 1'b0;     add_a = r_x;     add_b = r_hb; end
            S_CC:   begin alu_a = r_cp;      alu_b = r_dif; end
            S_C:    begin alu_op = ALU_SQRT; alu_a = r_c2; end
            S_UC:   begin alu_a = r_ub;      alu_b = r_c; end
            S_E10A: begin alu_a = C_HALF;    alu_b = r_ub; end
            S_E10:  begin alu_a = r_x;       alu_b = r_ub; end
            S_IC:   begin alu_op = ALU_DIV;  alu_a = C_ONE;   alu_b = r_c; end
            S_B1A:  begin alu_a = C_HALF;    alu_b = r_dif; end
            S_B1B:  begin alu_a = r_x;       alu_b = r_ic; end
            S_B1:   begin alu_a = r_x;       alu_b = r_ic; end
            S_V:    begin alu_a = r_b1;      alu_b = r_ub; end
            S_W1:   begin alu_a = C_HALF;    alu_b = r_v; end
            S_W:    begin alu_a = r_x;       alu_b = r_ub; end
            S_Q:    begin alu_a = C_HALF;    alu_b = r_ic; end
            S_QE:   begin alu_a = r_q;       alu_b = r_ub; end
            S_TW:   begin alu_a = C_TWO;     alu_b = r_w; end
            S_TV:   begin alu_a = C_TWO;     alu_b = r_v; end
            S_TB:   begin alu_a = C_NTWO;    alu_b = r_b1; end
            default: is_alu = 1'b0;
        endcase
    end

    assign add_res   = fadd(add_a, add_b);
    assign res_val   = is_alu ? alu_res : add_res;
    assign not_pos   = (res_val <= 0);
    assign alu_start = is_alu && !r_wait;

    // entry selection for the emit phase
    always_comb begin
        em_mode = EM_PASS;
        em_a    = '0;
        em_b    = '0;
        unique case (r_k)
            5'd0, 5'd6:  begin em_mode = EM_SUB;  em_a = r_ub; em_b = r_c; end
            5'd1, 5'd7:  em_a = r_ub;
            5'd2, 5'd8:  begin em_mode = EM_ADD;  em_a = r_ub; em_b = r_c; end
            5'd3, 5'd4, 5'd5: em_a = C_ONE;
            5'd9:        begin em_mode = EM_SUB;  em_a = r_hb; em_b = r_uc; end
            5'd10:       em_a = r_e10;
            5'd11:       begin em_mode = EM_ADD;  em_a = r_hb; em_b = r_uc; end
            5'd12:       begin em_mode = EM_ADD;  em_a = r_w;  em_b = r_qe; end
            5'd13:       begin em_mode = EM_NADD; em_a = r_v;  em_b = r_q; end
            5'd14, 5'd20: em_a = r_b1;
            5'd15:       begin em_mode = EM_SUB;  em_a = C_ONE; em_b = r_tw; end
            5'd16:       em_a = r_tv;
            5'd17:       em_a = r_tb;
            5'd18:       begin em_mode = EM_SUB;  em_a = r_w;  em_b = r_qe; end
            5'd19:       begin em_mode = EM_SUB;  em_a = r_q;  em_b = r_v; end
            default:     em_a = '0;
        endcase
        unique case (em_mode)
            EM_PASS: em_val = em_a;
            EM_ADD:  em_val = fadd(em_a, em_b);
            EM_SUB:  em_val = fadd(em_a, fneg(em_b));
            EM_NADD: em_val = fneg(fadd(em_a, em_b));
            default: em_val = em_a;
        endcase
    end

    assign em_last = (r_k == IDX_WIDTH'(NUM_ENTRIES - 1));

    always_comb begin
        unique case (r_state)
            S_IDLE:        step_done = i_item_valid;
            S_EMIT, S_ERR: step_done = !i_res_full;
            default:       step_done = is_alu ? alu_done : 1'b1;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (step_done) begin
            unique case (r_state)
                S_IDLE: n_state = i_item[6*W] ? S_ERR : S_VL;
                S_VL:   n_state = S_VR;
                S_VR:   n_state = S_GEL;
                S_GEL:  n_state = S_TL;
                S_TL:   n_state = S_K;
                S_K:    n_state = S_XL1;
                S_XL1:  n_state = S_XL2;
                S_XL2:  n_state = S_HL;
                S_HL:   n_state = S_GER;
                S_GER:  n_state = S_TR;
                S_TR:   n_state = S_XR1;
                S_XR1:  n_state = S_XR2;
                S_XR2:  n_state = S_HR;
                S_HR:   n_state = S_SL;
                S_SL:   n_state = S_SR;
                S_SR:   n_state = S_SSUM;
                S_SSUM: n_state = S_H1;
                S_H1:   n_state = S_H2;
                S_H2:   n_state = S_H3;
                S_H3:   n_state = S_HB;
                S_HB:   n_state = S_U1;
                S_U1:   n_state = S_U2;
                S_U2:   n_state = S_U3;
                S_U3:   n_state = S_UB;
                S_UB:   n_state = S_C1;
                S_C1:   n_state = S_C2;
                S_C2:   n_state = S_CP;
                S_CP:   n_state = not_pos ? S_ERR : S_CC;
                S_CC:   n_state = not_pos ? S_ERR : S_C;
                S_C:    n_state = S_UC;
                S_UC:   n_state = S_E10A;
                S_E10A: n_state = S_E10;
                S_E10:  n_state = S_IC;
                S_IC:   n_state = S_B1A;
                S_B1A:  n_state = S_B1B;
                S_B1B:  n_state = S_B1;
                S_B1:   n_state = S_V;
                S_V:    n_state = S_W1;
                S_W1:   n_state = S_W;
                S_W:    n_state = S_Q;
                S_Q:    n_state = S_QE;
                S_QE:   n_state = S_TW;
                S_TW:   n_state = S_TV;
                S_TV:   n_state = S_TB;
                S_TB:   n_state = S_EMIT;
                S_EMIT: n_state = em_last ? S_IDLE : S_EMIT;
                S_ERR:  n_state = S_IDLE;
                default: n_state = S_IDLE;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_item_pop = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        unique case (r_state)
            S_IDLE: o_item_pop = i_item_valid;
            S_EMIT: begin
                o_res_push        = !i_res_full;
                o_res.entry_index = r_k;
                o_res.entry_value = out32(em_val);
                o_res.error_code  = ERR_NONE;
                o_res.last_entry  = em_last;
            end
            S_ERR: begin
                o_res_push       = !i_res_full;
                o_res.error_code = r_err;
                o_res.last_entry = 1'b1;
            end
            default: o_item_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (alu_start) begin
                r_wait <= 1'b1;
            end else if (alu_done) begin
                r_wait <= 1'b0;
            end
            if (r_state == S_EMIT && step_done) begin
                r_k <= em_last ? '0 : r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_item_valid) begin
            r_err <= ERR_DENSITY;
            r_dl  <= i_item[6*W-1 -: W];
            r_ml  <= i_item[5*W-1 -: W];
            r_el  <= i_item[4*W-1 -: W];
            r_dr  <= i_item[3*W-1 -: W];
            r_mr  <= i_item[2*W-1 -: W];
            r_er  <= i_item[W-1:0];
            r_dif <= fadd(gam, fneg(C_ONE));
        end else if (step_done) begin
            unique case (r_state)
                S_VL:   r_vl   <= res_val;
                S_VR:   r_vr   <= res_val;
                S_GEL, S_TL, S_GER, S_TR: r_t <= res_val;
                S_K:    r_k2   <= res_val;
                S_XL1, S_XL2, S_XR1, S_XR2, S_H1, S_H3, S_U1, S_U3,
                S_C1, S_C2, S_E10A, S_B1A, S_B1B, S_W1: r_x <= res_val;
                S_HL:   r_hl   <= res_val;
                S_HR:   r_hr   <= res_val;
                S_SL:   r_sl   <= res_val;
                S_SR:   r_sr   <= res_val;
                S_SSUM: r_ssum <= res_val;
                S_H2, S_U2: r_y <= res_val;
                S_HB:   r_hb   <= res_val;
                S_UB:   r_ub   <= res_val;
                S_CP: begin
                    r_cp  <= res_val;
                    r_err <= ERR_SOUND;
                end
                S_CC: begin
                    r_c2  <= res_val;
                    r_err <= ERR_SOUND;
                end
                S_C:    r_c    <= res_val;
                S_UC:   r_uc   <= res_val;
                S_E10:  r_e10  <= res_val;
                S_IC:   r_ic   <= res_val;
                S_B1:   r_b1   <= res_val;
                S_V:    r_v    <= res_val;
                S_W:    r_w    <= res_val;
                S_Q:    r_q    <= res_val;
                S_QE:   r_qe   <= res_val;
                S_TW:   r_tw   <= res_val;
                S_TV:   r_tv   <= res_val;
                S_TB:   r_tb   <= res_val;
                default: r_y   <= r_y;
            endcase
        end
    end

endmodule

// File: sv/roe_average_eigensystem_unit.sv
// Roe-averaged 1D Euler eigensystem: top level with the gamma register,
// front, back and result queue. Uses rae_pkg, rae_front, rae_back, rae_fifo.
//
// Each accepted item (left/right density, momentum, energy, signed Q16.16) yields
// 21 result beats in index order (eigenvalues, right eigenvectors, inverse
// eigenvectors), or a single error beat with index 0, value 0 and last_entry set
// when a density is not positive or the averaged sound speed is not real. All
// multiplies, divides and square roots go through one shared iterative unit,
// and adds through a local saturating adder; a good item runs 7 divides,
// 3 roots, 28 multiplies and 6 adds in the back part, then emits its 21 beats;
// a density error goes straight to the error beat. The input queue holds two
// items, so push is taken while the back part is busy until the queue is full,
// and the result queue decouples pop from the sequencer. The user must write
// gamma_ratio through i_cfg_we only while the block is idle; the block itself
// does not enforce this. gamma_ratio resets to 1.4.
module roe_average_eigensystem_unit #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [rae_pkg::GAMMA_WIDTH-1:0]       i_cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [31:0]                    i_left_density,
    input  logic signed [31:0]                    i_left_momentum,
    input  logic signed [31:0]                    i_left_energy,
    input  logic signed [31:0]                    i_right_density,
    input  logic signed [31:0]                    i_right_momentum,
    input  logic signed [31:0]                    i_right_energy,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [rae_pkg::IDX_WIDTH-1:0]         o_entry_index,
    output logic signed [31:0]                    o_entry_value,
    output logic [1:0]                            o_error_code,
    output logic                                  o_last_entry
);
    import rae_pkg::*;

    localparam int W = WORD_WIDTH;
    localparam logic [63:0] GAMMA_RST_X = (64'd7 << FRAC_BITS) / 64'd5;

    logic [GAMMA_WIDTH-1:0] r_gamma;
    logic                   item_valid;
    logic [6*W:0]           item;
    logic                   item_pop;
    logic                   res_push;
    t_result                res_in;
    t_result                res_out;
    logic                   res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma <= GAMMA_RST_X[GAMMA_WIDTH-1:0];
        end else if (i_cfg_we) begin
            r_gamma <= i_cfg_data;
        end
    end

    rae_front #(
        .W(W)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_left_density   (i_left_density),
        .i_left_momentum  (i_left_momentum),
        .i_left_energy    (i_left_energy),
        .i_right_density  (i_right_density),
        .i_right_momentum (i_right_momentum),
        .i_right_energy   (i_right_energy),
        .o_item_valid     (item_valid),
        .o_item           (item),
        .i_item_pop       (item_pop)
    );

    rae_back #(
        .W(W),
        .F(FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gamma      (r_gamma),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .o_res_push   (res_push),
        .o_res        (res_in),
        .i_res_full   (res_full)
    );

    rae_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_entry_index = res_out.entry_index;
    assign o_entry_value = res_out.entry_value;
    assign o_error_code  = res_out.error_code;
    assign o_last_entry  = res_out.last_entry;

    // error beats stand alone
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code != ERR_NONE) |->
            (o_last_entry && o_entry_index == '0 && o_entry_value == '0))
        else $error("error beat is not a single index-0 entry");

    // entries of one item come out in index order
    a_idx_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_entry) |=>
            (empty || o_entry_index == $past(o_entry_index) + 1'b1))
        else $error("entry index out of sequence");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code == ERR_NONE) |->
            (o_last_entry == (o_entry_index == IDX_WIDTH'(NUM_ENTRIES - 1))))
        else $error("last_entry does not match final index");

endmodule
